@@ hdl/tmbc_pkg.sv @@
package tmbc_pkg;

	// map geometry; MAX_COLS and MAX_ROWS are powers of two so that an entry
	// address is the row and column counters side by side
	localparam int MAX_COLS    = 32;
	localparam int MAX_ROWS    = 32;
	localparam int COL_W       = $clog2(MAX_COLS);
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int ADDR_W      = COL_W + ROW_W;
	localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;

	// coordinate width: origin + 31*255 + 255 plus a sign, with margin
	localparam int CRD_W = 19;

	// configuration register indexes
	localparam logic [2:0] REG_TILE_WIDTH  = 3'd0;
	localparam logic [2:0] REG_TILE_HEIGHT = 3'd1;
	localparam logic [2:0] REG_ORIGIN_X    = 3'd2;
	localparam logic [2:0] REG_ORIGIN_Y    = 3'd3;
	localparam logic [2:0] REG_COLS        = 3'd4;
	localparam logic [2:0] REG_ROWS        = 3'd5;

	// request kinds
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// solid tile characters
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_C     = 8'h63;

	typedef struct packed {
		logic [7:0]  tile_width;
		logic [7:0]  tile_height;
		logic [15:0] origin_x;
		logic [15:0] origin_y;
	} geom_t;

	typedef struct packed {
		logic [15:0] box_x;
		logic [15:0] box_y;
		logic [7:0]  box_width;
		logic [7:0]  box_height;
	} box_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic hit;
	} scan_stat_t;

	function automatic logic is_solid(input logic [7:0] c);
		logic solid;
		case (c) inside
			CH_ONE, [CH_THREE:CH_NINE], [CH_A:CH_C]: solid = 1'b1;
			default:                                solid = 1'b0;
		endcase
		return solid;
	endfunction

endpackage

@@ hdl/tmbc_tile_ram.sv @@
module tmbc_tile_ram
	import tmbc_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem [STORE_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/tmbc_scan.sv @@
module tmbc_scan
	import tmbc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  box_t              box,
	input  geom_t             geom,
	input  logic [5:0]        cols_in_use,
	input  logic [5:0]        rows_in_use,
	input  logic              take,
	output logic [ADDR_W-1:0] raddr,
	input  logic [7:0]        rdata,
	output scan_stat_t        stat
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [5:0] cols_q;
	logic [5:0] rows_q;
	logic signed [CRD_W-1:0] tx_q, ty_q;
	logic signed [CRD_W-1:0] tx_s1, ty_s1;
	logic valid_s1;
	logic hit_q;
	box_t box_q;

	logic [5:0] cols_sat, rows_sat;
	logic last_col, last_row;
	logic signed [CRD_W-1:0] org_x, org_y, tw, th;
	logic signed [CRD_W-1:0] bx, by, bx_end, by_end, tx_end, ty_end;
	logic overlap;

	// clamp the scan extent to the map size
	assign cols_sat = (cols_in_use > 6'(MAX_COLS)) ? 6'(MAX_COLS) : cols_in_use;
	assign rows_sat = (rows_in_use > 6'(MAX_ROWS)) ? 6'(MAX_ROWS) : rows_in_use;

	assign last_col = ({1'b0, col_q} == 6'(cols_q - 6'd1));
	assign last_row = ({1'b0, row_q} == 6'(rows_q - 6'd1));

	assign org_x = $signed({{(CRD_W-16){geom.origin_x[15]}}, geom.origin_x});
	assign org_y = $signed({{(CRD_W-16){geom.origin_y[15]}}, geom.origin_y});
	assign tw    = $signed({{(CRD_W-8){1'b0}}, geom.tile_width});
	assign th    = $signed({{(CRD_W-8){1'b0}}, geom.tile_height});

	assign raddr = {row_q, col_q};

	// overlap test against the tile read last cycle
	assign bx     = $signed({{(CRD_W-16){box_q.box_x[15]}}, box_q.box_x});
	assign by     = $signed({{(CRD_W-16){box_q.box_y[15]}}, box_q.box_y});
	assign bx_end = bx + $signed({{(CRD_W-8){1'b0}}, box_q.box_width});
	assign by_end = by + $signed({{(CRD_W-8){1'b0}}, box_q.box_height});
	assign tx_end = tx_s1 + tw;
	assign ty_end = ty_s1 + th;
	assign overlap = !((bx >= tx_end) || (bx_end <= tx_s1) ||
		(by >= ty_end) || (by_end <= ty_s1));

	// sequencer: walk rows and columns, one read a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
			hit_q    <= 1'b0;
			cols_q   <= '0;
			rows_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					valid_s1 <= 1'b0;
					if (start) begin
						col_q  <= '0;
						row_q  <= '0;
						cols_q <= cols_sat;
						rows_q <= rows_sat;
						hit_q  <= 1'b0;
						if (cols_sat == 6'd0 || rows_sat == 6'd0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					valid_s1 <= 1'b1;
					if (last_col) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
						if (last_row) begin
							state_q <= ST_FLUSH;
						end
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				ST_FLUSH: begin
					valid_s1 <= 1'b0;
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// accumulate the flag
			if (valid_s1 && is_solid(rdata) && overlap) begin
				hit_q <= 1'b1;
			end
		end
	end

	// hold the query box and advance the tile corner along the scan
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			box_q <= box;
			tx_q  <= org_x;
			ty_q  <= org_y;
		end else if (state_q == ST_SCAN) begin
			if (last_col) begin
				tx_q <= org_x;
				ty_q <= ty_q + th;
			end else begin
				tx_q <= tx_q + tw;
			end
		end
		tx_s1 <= tx_q;
		ty_s1 <= ty_q;
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_DONE);
	assign stat.hit  = hit_q;

endmodule

@@ hdl/tile_map_box_collision.sv @@
// Tile map box collision.
// Input channel (in_valid/in_ready) takes requests of two kinds. A tile write
// (action 0) stores tile_code at tile_index and gives no result. A query
// (action 1) scans every tile in use, rows_in_use x cols_in_use, one
// tile-store read per cycle, and gives one result with its hit flag.
// With zero rows or columns no tile is scanned. A new request is taken only
// while no scan runs, so a query is not accepted until the last one is
// through and its result taken; every scan reads through the single read
// port of the tile store. Writes go at one per cycle while no scan runs.
// The result sits in an output register; the next request is taken while it
// waits. If the receiver stalls and a second query finishes, the scan holds
// in its done state and in_ready stays low until the result register frees.
// Configuration (cfg_we, cfg_index, cfg_data) must be written only while idle
// (the block does not enforce this). Reset clears control state and sets the
// configuration to its defaults (32x32 tiles, origin 0, 32 columns and rows);
// the tile store is not cleared and must be written before it is scanned.
module tile_map_box_collision
	import tmbc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [9:0]  tile_index,
	input  logic [7:0]  tile_code,
	input  logic [15:0] box_x,
	input  logic [15:0] box_y,
	input  logic [7:0]  box_width,
	input  logic [7:0]  box_height,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit
);

	geom_t geom_q;
	logic [5:0] cols_q, rows_q;
	scan_stat_t stat;
	logic [ADDR_W-1:0] raddr;
	logic [7:0] rdata;
	logic in_fire, ram_we, start, take;
	logic out_valid_q, hit_q;
	box_t box;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.tile_width  <= 8'd32;
			geom_q.tile_height <= 8'd32;
			geom_q.origin_x    <= 16'd0;
			geom_q.origin_y    <= 16'd0;
			cols_q             <= 6'd32;
			rows_q             <= 6'd32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TILE_WIDTH:  geom_q.tile_width  <= cfg_data[7:0];
				REG_TILE_HEIGHT: geom_q.tile_height <= cfg_data[7:0];
				REG_ORIGIN_X:    geom_q.origin_x    <= cfg_data;
				REG_ORIGIN_Y:    geom_q.origin_y    <= cfg_data;
				REG_COLS:        cols_q             <= cfg_data[5:0];
				REG_ROWS:        rows_q             <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// request decode
	assign in_ready = !stat.busy;
	assign in_fire  = in_valid && in_ready;
	assign ram_we   = in_fire && (action == ACT_WRITE);
	assign start    = in_fire && (action == ACT_QUERY);
	assign box      = '{box_x: box_x, box_y: box_y,
		box_width: box_width, box_height: box_height};

	tmbc_tile_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tile_index[ADDR_W-1:0]),
		.wdata (tile_code),
		.raddr (raddr),
		.rdata (rdata)
	);

	tmbc_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.box         (box),
		.geom        (geom_q),
		.cols_in_use (cols_q),
		.rows_in_use (rows_q),
		.take        (take),
		.raddr       (raddr),
		.rdata       (rdata),
		.stat        (stat)
	);

	// output register: load a finished scan when the slot is free
	assign take = stat.done && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			hit_q <= stat.hit;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;

`ifndef NO_ASSERTIONS
	a_query_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> stat.busy)
		else $error("query accepted but scan not running");

	a_result_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(stat.done))
		else $error("result appeared without a finished scan");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.done && !take) |=> (stat.done && $stable(stat.hit)))
		else $error("finished scan dropped before its result was taken");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> !ram_we)
		else $error("tile write during a scan");
`endif

endmodule
